// ===== hw/rtl/ltbp_pkg.sv =====
// Shared constants, result codes and controller/datapath interface types.
package ltbp_pkg;

    // Field widths fixed by the item format
    localparam int KEY_W  = 16;
    localparam int ADDR_W = 24;
    localparam int KIND_W = 2;

    // Default table depths
    localparam int LABEL_DEPTH_DEF   = 64;
    localparam int PENDING_DEPTH_DEF = 64;

    // Action codes of an input beat
    localparam logic ACT_DEFINE = 1'b0;
    localparam logic ACT_REF    = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PATCH  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEFINE = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic idx_clr;
        logic idx_inc;
        logic p_rd;
        logic p_rd_last;
        logic p_dec;
        logic p_move;
        logic p_push;
        logic l_rd;
        logic l_push;
        logic hold_patch;
        logic emit_def_full;
        logic emit_def_end;
        logic emit_hit;
        logic emit_miss;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_ref;
        logic def_full;
        logic pend_full;
        logic p_more;
        logic l_more;
        logic p_match;
        logic l_match;
        logic idx_is_last;
    } t_sts;

endpackage

// ===== hw/rtl/ltbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ltbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ltbp_ctl.sv =====
// Controller state machine that sequences table scans and result emission.
module ltbp_ctl import ltbp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHECK  = 4'd1;
    localparam logic [3:0] ST_P_TEST = 4'd2;
    localparam logic [3:0] ST_P_CMP  = 4'd3;
    localparam logic [3:0] ST_P_MOVE = 4'd4;
    localparam logic [3:0] ST_D_APP  = 4'd5;
    localparam logic [3:0] ST_L_TEST = 4'd6;
    localparam logic [3:0] ST_L_CMP  = 4'd7;
    localparam logic [3:0] ST_L_MISS = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    cmd.latch = 1'b1;
                    n_state   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.idx_clr = 1'b1;
                if (i_sts.is_ref) begin
                    n_state = ST_L_TEST;
                end else if (i_sts.def_full) begin
                    cmd.emit_def_full = 1'b1;
                    n_state           = ST_IDLE;
                end else begin
                    n_state = ST_P_TEST;
                end
            end
            ST_P_TEST: begin
                if (i_sts.p_more) begin
                    cmd.p_rd = 1'b1;
                    n_state  = ST_P_CMP;
                end else begin
                    n_state = ST_D_APP;
                end
            end
            ST_P_CMP: begin
                if (i_sts.p_match) begin
                    cmd.hold_patch = 1'b1;
                    cmd.p_dec      = 1'b1;
                    if (i_sts.idx_is_last) begin
                        n_state = ST_P_TEST;
                    end else begin
                        cmd.p_rd_last = 1'b1;
                        n_state       = ST_P_MOVE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                    n_state     = ST_P_TEST;
                end
            end
            ST_P_MOVE: begin
                // Move the last entry into the freed slot, then test that slot again
                cmd.p_move = 1'b1;
                n_state    = ST_P_TEST;
            end
            ST_D_APP: begin
                cmd.l_push       = 1'b1;
                cmd.emit_def_end = 1'b1;
                n_state          = ST_IDLE;
            end
            ST_L_TEST: begin
                if (i_sts.l_more) begin
                    cmd.l_rd = 1'b1;
                    n_state  = ST_L_CMP;
                end else begin
                    n_state = ST_L_MISS;
                end
            end
            ST_L_CMP: begin
                if (i_sts.l_match) begin
                    cmd.emit_hit = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    n_state     = ST_L_TEST;
                end
            end
            ST_L_MISS: begin
                cmd.emit_miss = 1'b1;
                cmd.p_push    = !i_sts.pend_full;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy  = (r_state != ST_IDLE);
    assign o_cmd = cmd;

endmodule

// ===== hw/rtl/ltbp_dp.sv =====
// Datapath: label and pending tables, counters, scan index and result registers.
module ltbp_dp import ltbp_pkg::*; #(
    parameter int LABEL_DEPTH   = LABEL_DEPTH_DEF,
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_action,
    input  logic [KEY_W-1:0]  i_label_id,
    input  logic [ADDR_W-1:0] i_cursor,
    output logic              o_strobe,
    output logic [KIND_W-1:0] o_kind,
    output logic              o_found,
    output logic [ADDR_W-1:0] o_value,
    output logic [ADDR_W-1:0] o_patch_location,
    output logic              o_table_full,
    output logic              o_last
);

    localparam int LA_W  = $clog2(LABEL_DEPTH);
    localparam int PA_W  = $clog2(PENDING_DEPTH);
    localparam int DC_W  = $clog2(LABEL_DEPTH + 1);
    localparam int PC_W  = $clog2(PENDING_DEPTH + 1);
    localparam int MAX_D = (LABEL_DEPTH > PENDING_DEPTH) ? LABEL_DEPTH : PENDING_DEPTH;
    localparam int IDX_W = $clog2(MAX_D + 1);
    localparam int ENT_W = KEY_W + ADDR_W;

    // Control state
    logic [DC_W-1:0]   r_dcount, n_dcount;
    logic [PC_W-1:0]   r_pcount, n_pcount;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_held_vld, n_held_vld;
    logic              r_out_vld, n_out_vld;

    // Payload state
    logic              r_action, n_action;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [ADDR_W-1:0] r_cur, n_cur;
    logic [ADDR_W-1:0] r_held_loc, n_held_loc;
    logic [KIND_W-1:0] r_out_kind, n_out_kind;
    logic              r_out_found, n_out_found;
    logic [ADDR_W-1:0] r_out_value, n_out_value;
    logic [ADDR_W-1:0] r_out_loc, n_out_loc;
    logic              r_out_full, n_out_full;
    logic              r_out_last, n_out_last;

    // Table ports
    logic              p_we, p_re;
    logic [PA_W-1:0]   p_waddr, p_raddr;
    logic [ENT_W-1:0]  p_wdata, p_rdata;
    logic [ENT_W-1:0]  l_rdata;
    logic [PC_W-1:0]   pcount_m1;
    logic [KEY_W-1:0]  p_rkey, l_rkey;
    logic [ADDR_W-1:0] p_rloc, l_raddr_val;

    assign pcount_m1   = PC_W'(r_pcount - 1'b1);
    assign p_rkey      = p_rdata[ENT_W-1 -: KEY_W];
    assign p_rloc      = p_rdata[ADDR_W-1:0];
    assign l_rkey      = l_rdata[ENT_W-1 -: KEY_W];
    assign l_raddr_val = l_rdata[ADDR_W-1:0];

    // Pending table: read at the scan slot or the last slot, write on move or push
    assign p_re    = i_cmd.p_rd || i_cmd.p_rd_last;
    assign p_raddr = i_cmd.p_rd_last ? pcount_m1[PA_W-1:0] : r_idx[PA_W-1:0];
    assign p_we    = i_cmd.p_move || i_cmd.p_push;
    assign p_waddr = i_cmd.p_move ? r_idx[PA_W-1:0] : r_pcount[PA_W-1:0];
    assign p_wdata = i_cmd.p_move ? p_rdata : {r_key, ADDR_W'(r_cur + 1'b1)};

    ltbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    ltbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (LABEL_DEPTH)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.l_push),
        .i_waddr (r_dcount[LA_W-1:0]),
        .i_wdata ({r_key, r_cur}),
        .i_re    (i_cmd.l_rd),
        .i_raddr (r_idx[LA_W-1:0]),
        .o_rdata (l_rdata)
    );

    // Status toward the controller
    always_comb begin
        o_sts.is_ref      = (r_action == ACT_REF);
        o_sts.def_full    = (r_dcount == DC_W'(LABEL_DEPTH));
        o_sts.pend_full   = (r_pcount == PC_W'(PENDING_DEPTH));
        o_sts.p_more      = (r_idx < IDX_W'(r_pcount));
        o_sts.l_more      = (r_idx < IDX_W'(r_dcount));
        o_sts.p_match     = (p_rkey == r_key);
        o_sts.l_match     = (l_rkey == r_key);
        o_sts.idx_is_last = (IDX_W'(r_idx + 1'b1) == IDX_W'(r_pcount));
    end

    // Counters, index and the held patch beat
    always_comb begin
        n_action   = r_action;
        n_key      = r_key;
        n_cur      = r_cur;
        n_dcount   = r_dcount;
        n_pcount   = r_pcount;
        n_idx      = r_idx;
        n_held_vld = r_held_vld;
        n_held_loc = r_held_loc;
        if (i_cmd.latch) begin
            n_action   = i_action;
            n_key      = i_label_id;
            n_cur      = i_cursor;
            n_held_vld = 1'b0;
        end
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end
        if (i_cmd.idx_inc) begin
            n_idx = IDX_W'(r_idx + 1'b1);
        end
        if (i_cmd.p_dec) begin
            n_pcount = pcount_m1;
        end
        if (i_cmd.p_push) begin
            n_pcount = PC_W'(r_pcount + 1'b1);
        end
        if (i_cmd.l_push) begin
            n_dcount = DC_W'(r_dcount + 1'b1);
        end
        if (i_cmd.hold_patch) begin
            n_held_vld = 1'b1;
            n_held_loc = p_rloc;
        end
        if (i_cmd.emit_def_end) begin
            n_held_vld = 1'b0;
        end
    end

    // Result beat: a patch is held back one step so the final one carries last
    always_comb begin
        n_out_vld   = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_found = r_out_found;
        n_out_value = r_out_value;
        n_out_loc   = r_out_loc;
        n_out_full  = r_out_full;
        n_out_last  = r_out_last;
        if (i_cmd.emit_def_full) begin
            n_out_vld   = 1'b1;
            n_out_kind  = KIND_DEFINE;
            n_out_found = 1'b0;
            n_out_value = r_cur;
            n_out_loc   = '0;
            n_out_full  = 1'b1;
            n_out_last  = 1'b1;
        end
        if ((i_cmd.hold_patch && r_held_vld) || (i_cmd.emit_def_end && r_held_vld)) begin
            n_out_vld   = 1'b1;
            n_out_kind  = KIND_PATCH;
            n_out_found = 1'b0;
            n_out_value = r_cur;
            n_out_loc   = r_held_loc;
            n_out_full  = 1'b0;
            n_out_last  = i_cmd.emit_def_end;
        end
        if (i_cmd.emit_def_end && !r_held_vld) begin
            n_out_vld   = 1'b1;
            n_out_kind  = KIND_DEFINE;
            n_out_found = 1'b0;
            n_out_value = r_cur;
            n_out_loc   = '0;
            n_out_full  = 1'b0;
            n_out_last  = 1'b1;
        end
        if (i_cmd.emit_hit) begin
            n_out_vld   = 1'b1;
            n_out_kind  = KIND_LOOKUP;
            n_out_found = 1'b1;
            n_out_value = l_raddr_val;
            n_out_loc   = '0;
            n_out_full  = 1'b0;
            n_out_last  = 1'b1;
        end
        if (i_cmd.emit_miss) begin
            n_out_vld   = 1'b1;
            n_out_kind  = KIND_LOOKUP;
            n_out_found = 1'b0;
            n_out_value = {ADDR_W{1'b1}};
            n_out_loc   = '0;
            n_out_full  = o_sts.pend_full;
            n_out_last  = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcount   <= '0;
            r_pcount   <= '0;
            r_idx      <= '0;
            r_held_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_dcount   <= n_dcount;
            r_pcount   <= n_pcount;
            r_idx      <= n_idx;
            r_held_vld <= n_held_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_key       <= n_key;
        r_cur       <= n_cur;
        r_held_loc  <= n_held_loc;
        r_out_kind  <= n_out_kind;
        r_out_found <= n_out_found;
        r_out_value <= n_out_value;
        r_out_loc   <= n_out_loc;
        r_out_full  <= n_out_full;
        r_out_last  <= n_out_last;
    end

    assign o_strobe         = r_out_vld;
    assign o_kind           = r_out_kind;
    assign o_found          = r_out_found;
    assign o_value          = r_out_value;
    assign o_patch_location = r_out_loc;
    assign o_table_full     = r_out_full;
    assign o_last           = r_out_last;

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.p_push |-> (r_pcount < PC_W'(PENDING_DEPTH)))
        else $error("pending push into a full list");

    a_define_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.l_push |-> (r_dcount < DC_W'(LABEL_DEPTH)))
        else $error("label append into a full table");

    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_last) |=> !r_out_vld)
        else $error("result beat right after a final beat");

    a_patch_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.p_dec |=> r_held_vld)
        else $error("pending entry removed without a held patch");
`endif

endmodule

// ===== hw/rtl/label_table_with_backpatch.sv =====
// Top level of the label table with forward-reference back-patching.
//
// One item is taken when start is high and busy is low; busy falls in the cycle that
// carries the item's final result, so the next item can be taken in that cycle.
// Results come out one per o_strobe pulse, each for exactly one cycle, and the
// receiver cannot stall them; o_last marks the final one. Both tables sit in
// single-port-read RAMs with registered read data, so every scanned entry takes a test
// state that issues the read and a compare state that checks it. A reference scans the
// defined labels until a hit (all of them on a miss). A define scans the pending
// entries, and each match adds a move of the last pending entry into the freed slot,
// except when the match is itself the last entry. Tables need no clearing after
// reset: only entries below the fill counts are ever read.
module label_table_with_backpatch import ltbp_pkg::*; #(
    parameter int LABEL_DEPTH   = LABEL_DEPTH_DEF,
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_action,
    input  logic [KEY_W-1:0]  i_label_id,
    input  logic [ADDR_W-1:0] i_cursor,
    output logic              o_strobe,
    output logic [KIND_W-1:0] o_kind,
    output logic              o_found,
    output logic [ADDR_W-1:0] o_value,
    output logic [ADDR_W-1:0] o_patch_location,
    output logic              o_table_full,
    output logic              o_last
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    ltbp_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // Tables and result registers
    ltbp_dp #(
        .LABEL_DEPTH   (LABEL_DEPTH),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_action         (i_action),
        .i_label_id       (i_label_id),
        .i_cursor         (i_cursor),
        .o_strobe         (o_strobe),
        .o_kind           (o_kind),
        .o_found          (o_found),
        .o_value          (o_value),
        .o_patch_location (o_patch_location),
        .o_table_full     (o_table_full),
        .o_last           (o_last)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the label table: directed and random define/reference beats.
module tb_top import ltbp_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LBL_DEPTH   = LABEL_DEPTH_DEF;
    localparam int PND_DEPTH   = PENDING_DEPTH_DEF;
    localparam int N_BEATS     = 260;
    localparam int SETTLE_CYC  = 400;
    localparam int MAX_PRINTED = 20;

    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] cursor;
    } beat_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              found;
        logic [ADDR_W-1:0] value;
        logic [ADDR_W-1:0] location;
        logic              full;
        logic              last;
    } answer_t;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              start      = 1'b0;
    logic              i_action   = ACT_DEFINE;
    logic [KEY_W-1:0]  i_label_id = '0;
    logic [ADDR_W-1:0] i_cursor   = '0;
    logic              busy;
    logic              o_strobe;
    logic [KIND_W-1:0] o_kind;
    logic              o_found;
    logic [ADDR_W-1:0] o_value;
    logic [ADDR_W-1:0] o_patch_location;
    logic              o_table_full;
    logic              o_last;

    // Shadow of the label table and the forward-reference list
    logic [KEY_W-1:0]  lbl_key  [LBL_DEPTH];
    logic [ADDR_W-1:0] lbl_addr [LBL_DEPTH];
    int                lbl_count = 0;
    logic [KEY_W-1:0]  fwd_key  [PND_DEPTH];
    logic [ADDR_W-1:0] fwd_loc  [PND_DEPTH];
    int                fwd_count = 0;

    beat_t   beat_q[$];
    answer_t want_q[$];
    beat_t   drv_beat;
    int      idle_pct  = 0;
    int      n_queued  = 0;
    int      n_beats   = 0;
    int      n_answers = 0;
    int      n_patches = 0;
    int      n_full    = 0;
    int      errors    = 0;

    label_table_with_backpatch i_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic answer_t make_answer(logic [KIND_W-1:0] kind, logic found,
            logic [ADDR_W-1:0] value, logic [ADDR_W-1:0] location, logic full);
        answer_t a;
        a.kind     = kind;
        a.found    = found;
        a.value    = value;
        a.location = location;
        a.full     = full;
        a.last     = 1'b0;
        return a;
    endfunction

    // Work out the answers of one accepted beat and advance the shadow tables
    task automatic resolve_beat(input beat_t b);
        answer_t out_q[$];
        answer_t a;
        int      i;
        bit      hit;
        if (b.action == ACT_DEFINE) begin
            if (lbl_count >= LBL_DEPTH) begin
                // drop the whole define, flag the full table
                out_q.push_back(make_answer(KIND_DEFINE, 1'b0, b.cursor, '0, 1'b1));
            end else begin
                // scan in slot order; a patched slot takes the last entry and is rechecked
                i = 0;
                while (i < fwd_count) begin
                    if (fwd_key[i] == b.key) begin
                        out_q.push_back(make_answer(KIND_PATCH, 1'b0, b.cursor,
                                                    fwd_loc[i], 1'b0));
                        fwd_count--;
                        fwd_key[i] = fwd_key[fwd_count];
                        fwd_loc[i] = fwd_loc[fwd_count];
                    end else begin
                        i++;
                    end
                end
                lbl_key[lbl_count]  = b.key;
                lbl_addr[lbl_count] = b.cursor;
                lbl_count++;
                if (out_q.size() == 0) begin
                    out_q.push_back(make_answer(KIND_DEFINE, 1'b0, b.cursor, '0, 1'b0));
                end
            end
        end else begin
            // earliest definition wins
            hit = 1'b0;
            for (i = 0; i < lbl_count && !hit; i++) begin
                if (lbl_key[i] == b.key) begin
                    hit = 1'b1;
                    a   = make_answer(KIND_LOOKUP, 1'b1, lbl_addr[i], '0, 1'b0);
                end
            end
            if (hit) begin
                out_q.push_back(a);
            end else if (fwd_count >= PND_DEPTH) begin
                out_q.push_back(make_answer(KIND_LOOKUP, 1'b0, '1, '0, 1'b1));
            end else begin
                fwd_key[fwd_count] = b.key;
                fwd_loc[fwd_count] = b.cursor + 1'b1;
                fwd_count++;
                out_q.push_back(make_answer(KIND_LOOKUP, 1'b0, '1, '0, 1'b0));
            end
        end
        // mark the final answer of the beat
        for (i = 0; i < out_q.size(); i++) begin
            a      = out_q[i];
            a.last = (i == out_q.size() - 1);
            want_q.push_back(a);
        end
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [ADDR_W-1:0] got,
                               input logic [ADDR_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("answer %0d: %s is %0h, want %0h",
                                      n_answers, name, got, want));
        end
    endtask

    // Driver: hold a beat until taken, then present the next one or idle
    always @(posedge i_clk) begin : drive
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                resolve_beat(drv_beat);
                n_beats++;
            end
            if (!start || !busy) begin
                if (beat_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    drv_beat = beat_q.pop_front();
                    start      <= 1'b1;
                    i_action   <= drv_beat.action;
                    i_label_id <= drv_beat.key;
                    i_cursor   <= drv_beat.cursor;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every strobed answer with the oldest expected one
    always @(posedge i_clk) begin : watch
        answer_t w;
        if (i_rst_n && o_strobe) begin
            n_answers++;
            if (o_kind == KIND_PATCH) n_patches++;
            if (o_table_full) n_full++;
            if (want_q.size() == 0) begin
                report_mismatch($sformatf("answer %0d arrived with nothing expected",
                                          n_answers));
            end else begin
                w = want_q.pop_front();
                check_field("kind", ADDR_W'(o_kind), ADDR_W'(w.kind));
                check_field("found", ADDR_W'(o_found), ADDR_W'(w.found));
                check_field("value", o_value, w.value);
                check_field("patch_location", o_patch_location, w.location);
                check_field("table_full", ADDR_W'(o_table_full), ADDR_W'(w.full));
                check_field("last", ADDR_W'(o_last), ADDR_W'(w.last));
            end
        end
    end

    task automatic add_beat(input logic action, input logic [KEY_W-1:0] key,
                            input logic [ADDR_W-1:0] cursor);
        beat_t b;
        b.action = action;
        b.key    = key;
        b.cursor = cursor;
        beat_q.push_back(b);
        n_queued++;
    endtask

    // Mostly random cursors, with the ends of the range now and then
    function automatic logic [ADDR_W-1:0] pick_cursor();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
    endfunction

    // Wait until every beat is taken and every answer has come
    task automatic wait_drained();
        do @(negedge i_clk);
        while (beat_q.size() != 0 || start || busy || want_q.size() != 0);
    endtask

    initial begin : stimulus
        logic [KEY_W-1:0] pool [12];
        logic [KEY_W-1:0] fill_keys[$];
        logic [KEY_W-1:0] hot;
        logic [KEY_W-1:0] key;
        int               k;
        int               n_def;
        int               n_ref;
        for (k = 0; k < 12; k++) begin
            pool[k] = KEY_W'($urandom_range(0, 16'h7FFF));
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, hits, misses, wrap, duplicates, rechecked slots
        idle_pct = 37;
        add_beat(ACT_REF,    16'h1234, 24'h000000);
        add_beat(ACT_DEFINE, 16'h1234, 24'hFFFFFF);
        add_beat(ACT_REF,    16'h1234, 24'h000010);
        add_beat(ACT_DEFINE, 16'h1234, 24'h000000);
        add_beat(ACT_REF,    16'h1234, 24'h000020);
        add_beat(ACT_DEFINE, 16'h0000, 24'h000000);
        add_beat(ACT_REF,    16'h0000, 24'hFFFFFF);
        add_beat(ACT_REF,    16'hFFFF, 24'hFFFFFF);
        add_beat(ACT_REF,    16'hFFFF, 24'h123456);
        add_beat(ACT_REF,    16'h5A5A, 24'h7FFFFF);
        add_beat(ACT_REF,    16'hFFFF, 24'hABCDEF);
        add_beat(ACT_DEFINE, 16'hFFFF, 24'h800000);
        add_beat(ACT_DEFINE, 16'h5A5A, 24'h555555);
        add_beat(ACT_DEFINE, 16'hA5A5, 24'hAAAAAA);
        add_beat(ACT_REF,    16'hA5A5, 24'h000001);
        add_beat(ACT_REF,    16'hFFFF, 24'h000002);
        add_beat(ACT_REF,    16'h0001, 24'h000000);
        add_beat(ACT_REF,    16'h0001, 24'hFFFFFE);
        add_beat(ACT_DEFINE, 16'h0002, 24'h000003);
        add_beat(ACT_DEFINE, 16'h0001, 24'h7FFFFF);
        wait_drained();

        // Mixed traffic over a small key pool, with a full drain halfway
        repeat (2) begin
            repeat (45) begin
                k = $urandom_range(0, 11);
                if ($urandom_range(0, 9) == 0) begin
                    add_beat(ACT_REF, KEY_W'($urandom_range(0, 16'hFFFF)), pick_cursor());
                end else if ($urandom_range(0, 99) < 30) begin
                    add_beat(ACT_DEFINE, pool[k], pick_cursor());
                end else begin
                    add_beat(ACT_REF, pool[k], pick_cursor());
                end
            end
            wait_drained();
        end

        // Fill the forward list past full, about half of it on one hot key
        idle_pct = 83;
        hot   = KEY_W'($urandom_range(16'h8000, 16'hFFFE));
        n_ref = PND_DEPTH - fwd_count + 4;
        repeat (n_ref) begin
            key = $urandom_range(0, 1) ? hot : KEY_W'($urandom_range(16'h8000, 16'hFFFE));
            fill_keys.push_back(key);
            add_beat(ACT_REF, key, pick_cursor());
        end
        add_beat(ACT_DEFINE, hot, pick_cursor());
        repeat (12) begin
            key = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
            if ($urandom_range(0, 2) == 0) begin
                add_beat(ACT_REF, key, pick_cursor());
            end else begin
                add_beat(ACT_DEFINE, key, pick_cursor());
            end
        end
        wait_drained();

        // Fill the label table past full, mixed with lookups, no gaps
        idle_pct = 0;
        n_def = LBL_DEPTH - lbl_count + 3;
        n_ref = N_BEATS - n_queued - n_def;
        if (n_ref < 12) n_ref = 12;
        while (n_def + n_ref > 0) begin
            if ($urandom_range(1, n_def + n_ref) <= n_def) begin
                n_def--;
                key = $urandom_range(0, 1) ? fill_keys[$urandom_range(0, fill_keys.size() - 1)]
                                           : KEY_W'($urandom_range(0, 16'hFFFF));
                add_beat(ACT_DEFINE, key, pick_cursor());
            end else begin
                n_ref--;
                k = $urandom_range(0, 9);
                if (k < 4) key = pool[$urandom_range(0, 11)];
                else if (k < 7) key = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
                else key = KEY_W'($urandom_range(0, 16'hFFFF));
                add_beat(ACT_REF, key, pick_cursor());
            end
        end
        wait_drained();

        // Let any stray answer show up before closing
        repeat (SETTLE_CYC) @(negedge i_clk);
        $display("covered %0d beats, %0d answers: %0d patch writes, %0d table-full flags",
                 n_beats, n_answers, n_patches, n_full);
        $display("closing state: %0d labels defined, %0d forward references open",
                 lbl_count, fwd_count);
        if (errors == 0 && want_q.size() == 0) begin
            $display("label_table_with_backpatch: match");
        end else begin
            $display("label_table_with_backpatch: mismatch");
        end
        $finish;
    end

    // Watchdog: stop a hung run
    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d answers still expected", want_q.size());
        $display("label_table_with_backpatch: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ltbp_pkg.sv
hw/rtl/ltbp_ram.sv
hw/rtl/ltbp_ctl.sv
hw/rtl/ltbp_dp.sv
hw/rtl/label_table_with_backpatch.sv
dv/tb_top.sv
